### sv/assert_macros.svh
// Assertion helper macros for the rotate block.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that holds whenever reset is low
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/irb_pkg.sv
// Package for the bilinear rotate block: constants and shared types.
// No dependencies.
`timescale 1ns / 1ps
package irb_pkg;
   localparam int ImgRowsDef = 240;
   localparam int ImgColsDef = 320;
   localparam int QOne = 512;
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_RENDER = 1'b1;
   localparam logic CSR_COS = 1'b0;
   localparam logic CSR_SIN = 1'b1;
endpackage

### sv/irb_bank.sv
// One bank of the four-way interleaved image store.
// Depends on nothing; used by image_rotate_bilinear.
`timescale 1ns / 1ps
module irb_bank #(
   parameter int DEPTH = 19200,
   parameter int AW = 15
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [23:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [23:0]   rd_data
);
   logic [23:0] mem [DEPTH];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### sv/image_rotate_bilinear.sv
// Top level of the bilinear image rotator: address pipe, banks and blend.
// Depends on irb_pkg, irb_bank and assert_macros.svh.
//
//   channel  dir  handshake          payload
//   req_     in   start & !busy      req_type, pixel_row/col, in_red/green/blue
//   rsp_     out  rsp_strobe 1 cyc   out_row/col, out_red/green/blue
//   csr_     in   csr_valid & ready  csr_index, csr_wdata
//
// One transaction per cycle; busy is never raised. A render result is
// registered through the multiply, source position, bank read, product and
// blend stages. Four banks split by row and column parity give all four
// neighbors in one read. Synchronous reset clears only pipeline valids, the
// load write enables and the cos/sin registers. The receiver cannot stall.
// A load is visible to a render accepted in the next cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module image_rotate_bilinear #(
   parameter int IMG_ROWS = irb_pkg::ImgRowsDef,
   parameter int IMG_COLS = irb_pkg::ImgColsDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_type,
   input  logic [7:0]  req_pixel_row,
   input  logic [8:0]  req_pixel_col,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_row,
   output logic [8:0]  rsp_out_col,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata
);
   import irb_pkg::*;
   localparam int HR = (IMG_ROWS + 1) / 2;
   localparam int HC = (IMG_COLS + 1) / 2;
   localparam int RB = $clog2(HR) > 0 ? $clog2(HR) : 1;
   localparam int CB = $clog2(HC) > 0 ? $clog2(HC) : 1;
   localparam int AW = RB + CB;
   localparam int DEPTH = HR * (1 << CB);
   localparam int SW = 34;

   logic signed [10:0] cos_ff, sin_ff;
   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= 11'sd512;
         sin_ff <= 11'sd0;
      end else if (csr_valid) begin
         if (csr_index == CSR_COS) cos_ff <= csr_wdata;
         else sin_ff <= csr_wdata;
      end
   end

   wire acc = start;
   // load path: bank chosen by parity, address by halves
   logic ld_ok;
   logic [3:0] ld_we;
   logic [AW-1:0] ld_addr;
   assign ld_ok = acc && req_type == REQ_LOAD && 32'(req_pixel_row) < IMG_ROWS
                  && 32'(req_pixel_col) < IMG_COLS;
   assign ld_addr = {RB'(req_pixel_row[7:1]), CB'(req_pixel_col[8:1])};
   always_comb begin
      ld_we = '0;
      ld_we[{req_pixel_row[0], req_pixel_col[0]}] = ld_ok;
   end

   // writes are registered before they land: a render accepted just before still reads old data
   logic [3:0] ld_we_ff;
   logic [AW-1:0] ld_addr_ff;
   logic [23:0] ld_data_ff;
   always_ff @(posedge clock) begin
      if (reset) ld_we_ff <= '0;
      else ld_we_ff <= ld_we;
      ld_addr_ff <= ld_addr;
      ld_data_ff <= {req_in_red, req_in_green, req_in_blue};
   end

   // stage 1: products
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [7:0] row1_ff, row2_ff, row3_ff, row4_ff, row5_ff;
   logic [8:0] col1_ff, col2_ff, col3_ff, col4_ff, col5_ff;
   logic signed [22:0] rc_ff, cs_ff, rs_ff, cc_ff;
   logic signed [11:0] r_d, c_d;
   assign r_d = $signed({4'd0, req_pixel_row}) - 12'(IMG_ROWS / 2);
   assign c_d = $signed({3'd0, req_pixel_col}) - 12'(IMG_COLS / 2);
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= acc && req_type == REQ_RENDER;
      row1_ff <= req_pixel_row;
      col1_ff <= req_pixel_col;
      rc_ff <= r_d * cos_ff;
      cs_ff <= c_d * sin_ff;
      rs_ff <= r_d * sin_ff;
      cc_ff <= c_d * cos_ff;
   end

   // stage 2: source position, range test, neighbor addresses
   logic signed [SW-1:0] sr, sc;
   assign sr = SW'(rc_ff) + SW'(cs_ff) + SW'((IMG_ROWS / 2) * QOne);
   assign sc = SW'(cc_ff) - SW'(rs_ff) + SW'((IMG_COLS / 2) * QOne);
   logic in_rng;
   assign in_rng = !sr[SW-1] && !sc[SW-1] && sr <= SW'(IMG_ROWS * QOne)
                   && sc <= SW'(IMG_COLS * QOne);
   logic [SW-10:0] ti, tj;
   logic [10:0] r0, r1, c0, c1;
   assign ti = sr[SW-1:9];
   assign tj = sc[SW-1:9];
   assign r0 = (ti >= (SW-9)'(IMG_ROWS - 1)) ? 11'(IMG_ROWS - 1) : 11'(ti);
   assign r1 = (ti + 1 >= (SW-9)'(IMG_ROWS - 1)) ? 11'(IMG_ROWS - 1) : 11'(ti + 1);
   assign c0 = (tj >= (SW-9)'(IMG_COLS - 1)) ? 11'(IMG_COLS - 1) : 11'(tj);
   assign c1 = (tj + 1 >= (SW-9)'(IMG_COLS - 1)) ? 11'(IMG_COLS - 1) : 11'(tj + 1);

   logic [8:0] fr2_ff, fc2_ff;
   logic [10:0] r0_ff, r1_ff, c0_ff, c1_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff && in_rng;
      row2_ff <= row1_ff; col2_ff <= col1_ff;
      fr2_ff <= sr[8:0]; fc2_ff <= sc[8:0];
      r0_ff <= r0; r1_ff <= r1; c0_ff <= c0; c1_ff <= c1;
   end

   // route by parity; a neighbor pair clamped to the edge shares one bank
   logic [AW-1:0] rd_addr [4];
   always_comb begin
      for (int b = 0; b < 4; b++) begin
         logic [10:0] rr, cc;
         rr = (r0_ff[0] == b[1]) ? r0_ff : r1_ff;
         cc = (c0_ff[0] == b[0]) ? c0_ff : c1_ff;
         rd_addr[b] = {RB'(rr[10:1]), CB'(cc[10:1])};
      end
   end

   logic [23:0] rd_data [4];
   for (genvar g = 0; g < 4; g++) begin : g_bank
      irb_bank #(.DEPTH(DEPTH), .AW(AW)) u_bank (
         .clock(clock), .wr_en(ld_we_ff[g]), .wr_addr(ld_addr_ff),
         .wr_data(ld_data_ff),
         .rd_addr(rd_addr[g]), .rd_data(rd_data[g]));
   end

   // stage 3: weights while banks read
   logic [9:0] ifr, ifc;
   assign ifr = 10'd512 - 10'(fr2_ff);
   assign ifc = 10'd512 - 10'(fc2_ff);
   logic [9:0] w_ff [4];
   logic [1:0] sel_ff [4];
   logic r_same, c_same;
   assign r_same = r0_ff == r1_ff;
   assign c_same = c0_ff == c1_ff;
   logic [19:0] p_tl, p_tr, p_bl, p_br;
   assign p_tl = ifr * ifc;
   assign p_tr = ifr * 10'(fc2_ff);
   assign p_bl = 10'(fr2_ff) * ifc;
   assign p_br = 10'(fr2_ff) * 10'(fc2_ff);
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else s3_v_ff <= s2_v_ff;
      row3_ff <= row2_ff; col3_ff <= col2_ff;
      w_ff[0] <= p_tl[18:9]; w_ff[1] <= p_tr[18:9];
      w_ff[2] <= p_bl[18:9]; w_ff[3] <= p_br[18:9];
      // bank of each neighbor tl/tr/bl/br; the far one only when not clamped
      for (int n = 0; n < 4; n++) begin
         sel_ff[n] <= {r0_ff[0] ^ (n[1] & !r_same), c0_ff[0] ^ (n[0] & !c_same)};
      end
   end

   // stage 4: per-neighbor products from the selected bank
   logic [17:0] prod_ff [4][3];
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else s4_v_ff <= s3_v_ff;
      row4_ff <= row3_ff; col4_ff <= col3_ff;
      for (int n = 0; n < 4; n++) begin
         for (int ch = 0; ch < 3; ch++) begin
            prod_ff[n][ch] <= w_ff[n] * rd_data[sel_ff[n]][8*(2-ch) +: 8];
         end
      end
   end

   // stage 5: sum and scale
   logic [7:0] ch_ff [3];
   always_ff @(posedge clock) begin
      logic [19:0] s;
      if (reset) s5_v_ff <= 1'b0;
      else s5_v_ff <= s4_v_ff;
      row5_ff <= row4_ff; col5_ff <= col4_ff;
      for (int ch = 0; ch < 3; ch++) begin
         s = 20'(prod_ff[0][ch]) + 20'(prod_ff[1][ch]) + 20'(prod_ff[2][ch])
             + 20'(prod_ff[3][ch]);
         ch_ff[ch] <= s[16:9];
      end
   end

   assign rsp_strobe = s5_v_ff;
   assign rsp_out_row = row5_ff;
   assign rsp_out_col = col5_ff;
   assign rsp_out_red = ch_ff[0];
   assign rsp_out_green = ch_ff[1];
   assign rsp_out_blue = ch_ff[2];

   `ASSERT_NEXT(a_pipe1, clock, reset, s2_v_ff, s3_v_ff, "stage 3 lost item")
   `ASSERT_NEXT(a_pipe2, clock, reset, s4_v_ff, rsp_strobe, "result lost")
   `ASSERT_CLK(a_load, clock, reset, $countones(ld_we) <= 1, "two banks written")
endmodule

### tb/sv/irb_checker.sv
// Checker for the bilinear rotate block: watches the request, result and CSR
// channels, predicts each render result and compares it. Depends on irb_pkg.
`timescale 1ns / 1ps
module irb_checker
   import irb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_type,
   input  logic [7:0]  req_pixel_row,
   input  logic [8:0]  req_pixel_col,
   input  logic [7:0]  req_in_red,
   input  logic [7:0]  req_in_green,
   input  logic [7:0]  req_in_blue,
   input  logic        rsp_strobe,
   input  logic [7:0]  rsp_out_row,
   input  logic [8:0]  rsp_out_col,
   input  logic [7:0]  rsp_out_red,
   input  logic [7:0]  rsp_out_green,
   input  logic [7:0]  rsp_out_blue,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   localparam int NumPixels = ImgRowsDef * ImgColsDef;

   typedef struct packed {
      logic [7:0] row;
      logic [8:0] col;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } drawn_pixel_type;

   drawn_pixel_type drawn_q[$];
   logic [23:0] image_mem [0:NumPixels-1];
   logic signed [10:0] cos_reg;
   logic signed [10:0] sin_reg;

   initial begin
      for (int i = 0; i < NumPixels; i++) image_mem[i] = '0;
      fail_count = 0;
      pending = 0;
   end

   function automatic longint clamp_to(longint v, longint last);
      if (v < 0) return 0;
      if (v > last) return last;
      return v;
   endfunction

   function automatic logic [23:0] neighbor(longint r, longint c);
      return image_mem[clamp_to(r, ImgRowsDef - 1) * ImgColsDef
                       + clamp_to(c, ImgColsDef - 1)];
   endfunction

   // weighted sum of one color channel, truncated by QOne
   function automatic logic [7:0] blend_channel(logic [23:0] p0, logic [23:0] p1,
                                                logic [23:0] p2, logic [23:0] p3,
                                                int sh, longint w0, longint w1,
                                                longint w2, longint w3);
      longint acc;
      acc = w0 * longint'((p0 >> sh) & 8'hff) + w1 * longint'((p1 >> sh) & 8'hff)
          + w2 * longint'((p2 >> sh) & 8'hff) + w3 * longint'((p3 >> sh) & 8'hff);
      return 8'(acc / QOne);
   endfunction

   // maps a destination pixel back to the source and blends; 0 when outside
   function automatic bit rotate_pixel(logic [7:0] row, logic [8:0] col,
                                       output drawn_pixel_type px);
      longint r, c, sr, sc, ti, tj, fr, fc, wtl, wtr, wbl, wbr;
      logic [23:0] ptl, ptr, pbl, pbr;
      r = longint'(row) - ImgRowsDef / 2;
      c = longint'(col) - ImgColsDef / 2;
      sr = r * longint'(cos_reg) + c * longint'(sin_reg) + (ImgRowsDef / 2) * QOne;
      sc = -r * longint'(sin_reg) + c * longint'(cos_reg) + (ImgColsDef / 2) * QOne;
      px = '0;
      if (sr < 0 || sc < 0 || sr > ImgRowsDef * QOne || sc > ImgColsDef * QOne)
         return 0;
      ti = sr / QOne;
      tj = sc / QOne;
      fr = sr % QOne;
      fc = sc % QOne;
      wtl = ((QOne - fr) * (QOne - fc)) / QOne;
      wtr = ((QOne - fr) * fc) / QOne;
      wbl = (fr * (QOne - fc)) / QOne;
      wbr = (fr * fc) / QOne;
      ptl = neighbor(ti, tj);
      ptr = neighbor(ti, tj + 1);
      pbl = neighbor(ti + 1, tj);
      pbr = neighbor(ti + 1, tj + 1);
      px.row = row;
      px.col = col;
      px.red = blend_channel(ptl, ptr, pbl, pbr, 16, wtl, wtr, wbl, wbr);
      px.green = blend_channel(ptl, ptr, pbl, pbr, 8, wtl, wtr, wbl, wbr);
      px.blue = blend_channel(ptl, ptr, pbl, pbr, 0, wtl, wtr, wbl, wbr);
      return 1;
   endfunction

   always @(posedge clock) begin
      drawn_pixel_type want;
      drawn_pixel_type got;
      if (reset) begin
         cos_reg = 11'sd512;
         sin_reg = 11'sd0;
         drawn_q.delete();
      end else begin
         // result side first: a new render cannot answer in the same cycle
         if (rsp_strobe) begin
            got = '{rsp_out_row, rsp_out_col, rsp_out_red, rsp_out_green, rsp_out_blue};
            if (drawn_q.size() == 0) begin
               $error("result with no pending render: row %0d col %0d", got.row, got.col);
               fail_count++;
            end else begin
               want = drawn_q.pop_front();
               if (got.row !== want.row) begin
                  $error("out_row expected %0d actual %0d", want.row, got.row);
                  fail_count++;
               end
               if (got.col !== want.col) begin
                  $error("out_col expected %0d actual %0d", want.col, got.col);
                  fail_count++;
               end
               if (got.red !== want.red) begin
                  $error("out_red expected %0d actual %0d", want.red, got.red);
                  fail_count++;
               end
               if (got.green !== want.green) begin
                  $error("out_green expected %0d actual %0d", want.green, got.green);
                  fail_count++;
               end
               if (got.blue !== want.blue) begin
                  $error("out_blue expected %0d actual %0d", want.blue, got.blue);
                  fail_count++;
               end
            end
         end
         // request transaction: predict against the store as it stood before
         if (start && !busy) begin
            if (req_type == REQ_RENDER) begin
               if (rotate_pixel(req_pixel_row, req_pixel_col, want))
                  drawn_q.push_back(want);
            end else if (req_pixel_row < ImgRowsDef && req_pixel_col < ImgColsDef) begin
               image_mem[req_pixel_row * ImgColsDef + req_pixel_col] =
                  {req_in_red, req_in_green, req_in_blue};
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_COS) cos_reg = csr_wdata;
            else sin_reg = csr_wdata;
         end
      end
      pending = drawn_q.size();
   end
endmodule

### tb/sv/tb_image_rotate_bilinear.sv
// Top of the rotate block testbench: clock, reset, stimulus and verdict.
// Depends on irb_pkg, image_rotate_bilinear and irb_checker.
`timescale 1ns / 1ps
module tb_image_rotate_bilinear;
   import irb_pkg::*;

   localparam int DrainCycles = 12;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_type;
   logic [7:0]  req_pixel_row;
   logic [8:0]  req_pixel_col;
   logic [7:0]  req_in_red;
   logic [7:0]  req_in_green;
   logic [7:0]  req_in_blue;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_row;
   logic [8:0]  rsp_out_col;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [10:0] csr_wdata;
   int          fail_count;
   int          pending;

   // stimulus-side view: which source pixels hold data, current rotation
   bit          loaded [0:ImgRowsDef*ImgColsDef-1];
   int          cur_cos;
   int          cur_sin;

   image_rotate_bilinear DUT (.*);

   irb_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // one request transaction; start stays high if the next call follows
   task automatic send_req(logic kind, logic [7:0] row, logic [8:0] col,
                           logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      start <= 1'b1;
      req_type <= kind;
      req_pixel_row <= row;
      req_pixel_col <= col;
      req_in_red <= red;
      req_in_green <= green;
      req_in_blue <= blue;
      forever begin
         @(negedge clock);
         if (!busy) begin
            @(posedge clock);
            break;
         end
         @(posedge clock);
      end
      if (kind == REQ_LOAD && row < ImgRowsDef && col < ImgColsDef)
         loaded[row * ImgColsDef + col] = 1'b1;
   endtask

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 99) < 60) ? 0 :
          ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // wait for all renders to come back, then past the pipeline depth
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [10:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) begin
            @(posedge clock);
            break;
         end
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_rotation(int c, int s);
      drain();
      write_csr(CSR_COS, 11'(c));
      write_csr(CSR_SIN, 11'(s));
      cur_cos = $signed(11'(c));
      cur_sin = $signed(11'(s));
   endtask

   // render a destination pixel, first loading any source neighbor not yet held
   task automatic render_at(logic [7:0] row, logic [8:0] col);
      longint r, c, sr, sc, ti, tj, rr, cc;
      r = longint'(row) - ImgRowsDef / 2;
      c = longint'(col) - ImgColsDef / 2;
      sr = r * cur_cos + c * cur_sin + (ImgRowsDef / 2) * QOne;
      sc = -r * cur_sin + c * cur_cos + (ImgColsDef / 2) * QOne;
      if (sr >= 0 && sc >= 0 && sr <= ImgRowsDef * QOne && sc <= ImgColsDef * QOne) begin
         ti = sr / QOne;
         tj = sc / QOne;
         for (int k = 0; k < 4; k++) begin
            rr = ti + k / 2;
            cc = tj + k % 2;
            if (rr > ImgRowsDef - 1) rr = ImgRowsDef - 1;
            if (cc > ImgColsDef - 1) cc = ImgColsDef - 1;
            if (!loaded[rr * ImgColsDef + cc])
               send_req(REQ_LOAD, 8'(rr), 9'(cc), 8'($urandom), 8'($urandom),
                        8'($urandom));
         end
      end
      send_req(REQ_RENDER, row, col, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         send_req(REQ_LOAD, 8'($urandom_range(0, ImgRowsDef - 1)),
                  9'($urandom_range(0, ImgColsDef - 1)),
                  8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 25) begin
         // loads off the image are dropped
         send_req(REQ_LOAD, 8'($urandom_range(ImgRowsDef, 255)), 9'($urandom),
                  8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 32) begin
         render_at(8'($urandom), 9'($urandom));
      end else begin
         render_at(8'($urandom_range(0, ImgRowsDef - 1)),
                   9'($urandom_range(0, ImgColsDef - 1)));
      end
      idle_gap();
   endtask

   initial begin
      int rot_cos [8] = '{512, 0, -512, 0, 362, -443, -1024, 1023};
      int rot_sin [8] = '{0, 512, 0, -512, 362, 256, 1023, -1024};
      start = 1'b0;
      req_type = REQ_LOAD;
      req_pixel_row = '0;
      req_pixel_col = '0;
      req_in_red = '0;
      req_in_green = '0;
      req_in_blue = '0;
      csr_valid = 1'b0;
      csr_index = CSR_COS;
      csr_wdata = '0;
      cur_cos = 512;
      cur_sin = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, color extremes, dropped load, bounds, load then render
      send_req(REQ_LOAD, 8'd0, 9'd0, 8'hff, 8'hff, 8'hff);
      send_req(REQ_LOAD, 8'd239, 9'd319, 8'h00, 8'h00, 8'h00);
      send_req(REQ_LOAD, 8'd255, 9'd511, 8'h55, 8'haa, 8'h0f);
      send_req(REQ_LOAD, 8'd100, 9'd400, 8'h12, 8'h34, 8'h56);
      render_at(8'd0, 9'd0);
      render_at(8'd239, 9'd319);
      render_at(8'd240, 9'd320);
      render_at(8'd255, 9'd511);
      render_at(8'd120, 9'd160);
      send_req(REQ_LOAD, 8'd120, 9'd160, 8'h80, 8'h7f, 8'h01);
      render_at(8'd120, 9'd160);
      idle_gap();
      set_rotation(-512, 512);
      render_at(8'd0, 9'd0);
      render_at(8'd239, 9'd319);
      render_at(8'd60, 9'd200);
      render_at(8'd200, 9'd10);

      // random phases over a set of rotations, extremes included; each render
      // usually brings its neighbor loads along
      for (int ph = 0; ph < 10; ph++) begin
         if (ph < 8) set_rotation(rot_cos[ph], rot_sin[ph]);
         else set_rotation($urandom_range(0, 1024) - 512, $urandom_range(0, 1024) - 512);
         for (int i = 0; i < 50; i++) begin
            random_item();
            // hold off the sender once until everything has come back
            if (ph == 4 && i == 25) drain();
         end
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
